/* sv/kalarm_pkg.sv */
// ----------------------------------------------------------------------------
// kalarm_pkg
// Shared types and constants for the keypad arm/alarm controller.
// ----------------------------------------------------------------------------
`default_nettype none

package kalarm_pkg;

  // Item kinds carried on the mode field
  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Key codes and reset values
  localparam logic [7:0] HASH_KEY     = 8'h23;  // '#'
  localparam logic [7:0] CODE_FILL    = 8'h30;  // '0', stored code after reset
  localparam logic [7:0] START_RESET  = 8'd15;

  // One item as seen by the update logic, with its fire strobe
  typedef struct packed {
    logic       fire;
    logic       mode;
    logic [7:0] key_code;
    logic       motion;
  } step_t;

endpackage

`default_nettype wire

/* sv/keypad_arm_alarm_controller_core.sv */
// ----------------------------------------------------------------------------
// keypad_arm_alarm_controller_core
// Keypad code lock with motion alarm: one result per key or sensor tick.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------------
//  in       | in_valid / in_stall      | mode, key_code, motion
//  out      | out_valid / out_stall    | armed_now, siren_on, ticks_left,
//           |                          | keys_held, code_invalid
//  cfg      | cfg_wr_en                | cfg_wr_data (countdown start)
//
//  One transaction per cycle sustained while out_stall stays low; each passes the
//  input register, then the state update lands in the result register.
//  The state update runs in the single step between those two registers.
//  rst (synchronous) empties both registers and restores all state.
//  in_stall rises only while the input register is full and a held result is
//  stalled downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_arm_alarm_controller_core #(
  parameter int CODE_KEYS = 4
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire        mode,
  input  wire  [7:0] key_code,
  input  wire        motion,
  output logic       out_valid,
  input  wire        out_stall,
  output logic       armed_now,
  output logic       siren_on,
  output logic [7:0] ticks_left,
  output logic [2:0] keys_held,
  output logic       code_invalid,
  input  wire        cfg_wr_en,
  input  wire  [7:0] cfg_wr_data
);
  import kalarm_pkg::*;

  logic       ir_valid;
  logic       ir_mode;
  logic [7:0] ir_key;
  logic       ir_motion;
  logic       advance;
  step_t      step;
  logic       armed;
  logic       armed_next;
  logic [2:0] keys_held_next;
  logic       bad;
  logic       siren_next;
  logic [7:0] countdown_next;

  // Input register moves forward whenever the result slot is free
  assign advance  = ir_valid && (!out_valid || !out_stall);
  assign in_stall = ir_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (!in_stall) begin
      ir_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ir_mode   <= mode;
      ir_key    <= key_code;
      ir_motion <= motion;
    end
  end

  assign step = '{fire: advance, mode: ir_mode, key_code: ir_key, motion: ir_motion};

  // Update logic
  kalarm_keys #(.CODE_KEYS(CODE_KEYS)) u_keys (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .armed          (armed),
    .armed_next     (armed_next),
    .keys_held_next (keys_held_next),
    .bad            (bad)
  );

  kalarm_motion u_motion (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .armed          (armed),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .siren_next     (siren_next),
    .countdown_next (countdown_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      armed_now    <= armed_next;
      siren_on     <= siren_next;
      ticks_left   <= countdown_next;
      keys_held    <= keys_held_next;
      code_invalid <= bad;
    end
  end

endmodule

`default_nettype wire

/* sv/kalarm_keys.sv */
// ----------------------------------------------------------------------------
// kalarm_keys
// Keypad side: entry buffer, stored code, armed flag and '#' handling.
// ----------------------------------------------------------------------------
`default_nettype none

module kalarm_keys #(
  parameter int CODE_KEYS = 4
) (
  input  wire                 clk,
  input  wire                 rst,
  input  kalarm_pkg::step_t   step,
  output logic                armed,
  output logic                armed_next,
  output logic [2:0]          keys_held_next,
  output logic                bad
);
  import kalarm_pkg::*;

  localparam int LEN_W = $clog2(CODE_KEYS + 1);
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(CODE_KEYS);

  logic [7:0]       stored_code [CODE_KEYS];
  logic [7:0]       stored_code_next [CODE_KEYS];
  logic [7:0]       entry_keys [CODE_KEYS];
  logic [7:0]       entry_keys_next [CODE_KEYS];
  logic [LEN_W-1:0] entry_len;
  logic [LEN_W-1:0] entry_len_next;
  logic             match;
  logic [LEN_W+2:0] len_wide;

  // Full compare of entry against stored code
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_KEYS; i++) begin
      if (stored_code[i] != entry_keys[i]) match = 1'b0;
    end
  end

  // Key event update
  always_comb begin
    armed_next       = armed;
    stored_code_next = stored_code;
    entry_keys_next  = entry_keys;
    entry_len_next   = entry_len;
    bad              = 1'b0;
    if (step.fire && step.mode == MODE_KEY) begin
      if (step.key_code == HASH_KEY) begin
        if (!armed) begin
          if (entry_len == FULL_LEN) begin
            stored_code_next = entry_keys;
            armed_next       = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end else if (match) begin
          armed_next = 1'b0;
        end else begin
          bad = 1'b1;
        end
      end else if (entry_len < FULL_LEN) begin
        for (int i = 0; i < CODE_KEYS; i++) begin
          if (LEN_W'(i) == entry_len) entry_keys_next[i] = step.key_code;
        end
        entry_len_next = entry_len + 1'b1;
      end else begin
        // buffer full: clear it and drop the key
        for (int i = 0; i < CODE_KEYS; i++) entry_keys_next[i] = '0;
        entry_len_next = '0;
      end
    end
  end

  // keys_held carries the low three bits of the count
  assign len_wide       = (LEN_W + 3)'(entry_len_next);
  assign keys_held_next = len_wide[2:0];

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= 1'b1;
      entry_len <= '0;
      for (int i = 0; i < CODE_KEYS; i++) begin
        stored_code[i] <= CODE_FILL;
        entry_keys[i]  <= '0;
      end
    end else begin
      armed       <= armed_next;
      entry_len   <= entry_len_next;
      stored_code <= stored_code_next;
      entry_keys  <= entry_keys_next;
    end
  end

endmodule

`default_nettype wire

/* sv/kalarm_motion.sv */
// ----------------------------------------------------------------------------
// kalarm_motion
// Sensor side: countdown, motion tracking, siren flag and start register.
// ----------------------------------------------------------------------------
`default_nettype none

module kalarm_motion (
  input  wire                 clk,
  input  wire                 rst,
  input  kalarm_pkg::step_t   step,
  input  wire                 armed,
  input  wire                 cfg_wr_en,
  input  wire  [7:0]          cfg_wr_data,
  output logic                siren_next,
  output logic [7:0]          countdown_next
);
  import kalarm_pkg::*;

  logic [7:0] countdown_start;
  logic [7:0] countdown;
  logic       counting;
  logic       counting_next;
  logic       motion_seen;
  logic       motion_seen_next;
  logic       siren;

  // Tick update
  always_comb begin
    countdown_next   = countdown;
    counting_next    = counting;
    motion_seen_next = motion_seen;
    siren_next       = siren;
    if (step.fire && step.mode == MODE_TICK) begin
      if (counting) begin
        if (countdown != 8'd0) countdown_next = countdown - 8'd1;
        else                   siren_next     = 1'b1;
        if (!(step.motion && armed)) begin
          counting_next    = 1'b0;
          motion_seen_next = 1'b1;
        end
      end else if (step.motion) begin
        countdown_next = countdown_start;
        if (armed) counting_next    = 1'b1;
        else       motion_seen_next = 1'b1;
      end else if (motion_seen) begin
        if (armed) siren_next = 1'b0;
        motion_seen_next = 1'b0;
      end
    end
  end

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      countdown_start <= START_RESET;
      countdown       <= '0;
      counting        <= 1'b0;
      motion_seen     <= 1'b0;
      siren           <= 1'b0;
    end else begin
      if (cfg_wr_en) countdown_start <= cfg_wr_data;
      countdown   <= countdown_next;
      counting    <= counting_next;
      motion_seen <= motion_seen_next;
      siren       <= siren_next;
    end
  end

endmodule

`default_nettype wire

/* sv/kalarm_checker.sv */
// ----------------------------------------------------------------------------
// kalarm_checker
// Port-level checks for the keypad arm/alarm controller, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module kalarm_checker #(
  parameter int CODE_KEYS = 4
) (
  input wire       clk,
  input wire       rst,
  input wire       in_valid,
  input wire       in_stall,
  input wire       mode,
  input wire [7:0] key_code,
  input wire       motion,
  input wire       out_valid,
  input wire       out_stall,
  input wire       armed_now,
  input wire       siren_on,
  input wire [7:0] ticks_left,
  input wire [2:0] keys_held,
  input wire       code_invalid
);

  // No result shows right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Input stalls only behind a stalled, held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without downstream back-pressure");

  // Entry count never exceeds the code length
  a_keys_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CODE_KEYS >= 7 || 32'(keys_held) <= CODE_KEYS))
    else $error("keys_held beyond code length");

  // A stalled input transaction holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> (in_valid && $stable(mode)
      && $stable(key_code) && $stable(motion)))
    else $error("stalled input changed");

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(ticks_left)
      && $stable(armed_now) && $stable(keys_held) && $stable(siren_on)
      && $stable(code_invalid)))
    else $error("stalled result changed");

endmodule

bind keypad_arm_alarm_controller_core kalarm_checker #(.CODE_KEYS(CODE_KEYS)) u_checker (.*);

`default_nettype wire
